/* rtl/blist_pkg.sv */
`timescale 1ns / 1ps
// shared widths, defaults and operation codes for the bounded list block
// no dependencies

package blist_pkg;

	localparam int SIZE_DEF = 8;

	localparam int KIND_W = 3;
	localparam int POS_W  = 4;
	localparam int VAL_W  = 32;
	localparam int IDX_W  = 3;
	localparam int CNT_W  = 4;

	localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
	localparam logic [KIND_W-1:0] KIND_FIND   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

endpackage

/* rtl/blist_alu.sv */
`timescale 1ns / 1ps
// shared unit of the list sequencer: one 32-bit equality compare and the
// walk index step, depends on blist_pkg

module blist_alu #(
	parameter int CW = 4
) (
	input  logic [blist_pkg::VAL_W-1:0] a,
	input  logic [blist_pkg::VAL_W-1:0] b,
	input  logic [CW-1:0]               idx,
	output logic                        eq,
	output logic [CW-1:0]               idx_inc,
	output logic [CW-1:0]               idx_dec
);
	import blist_pkg::*;

	assign eq      = (a == b);
	assign idx_inc = idx + CW'(1);
	assign idx_dec = idx - CW'(1);

endmodule

/* rtl/bounded_list_insert_remove_search_top.sv */
`timescale 1ns / 1ps
// Ordered list of up to SIZE signed 32-bit values with insert, find last, remove all,
// read and clear. The list lives in a one-write, one-read memory with registered read
// data; a sequencer walks it one entry at a time through a shared compare unit.
// Clear, a refused request and an unused code go straight to done; read waits for the
// read data; insert shifts each entry from position up one place, then writes the
// value; find last inspects entries from the top and stops at the first hit; remove
// all walks the list and packs kept entries down. The sequencer is back in idle at
// the edge that loads the result, and a result register that is still full holds it
// in its last state. The next request is taken once the sequencer is idle, even while
// the last result still waits at the output. Depends on blist_pkg and blist_alu.

module bounded_list_insert_remove_search_top #(
	parameter int SIZE = blist_pkg::SIZE_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [blist_pkg::KIND_W-1:0]       kind,
	input  logic [blist_pkg::POS_W-1:0]        position,
	input  logic signed [blist_pkg::VAL_W-1:0] value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               ok,
	output logic                               found,
	output logic [blist_pkg::IDX_W-1:0]        index,
	output logic signed [blist_pkg::VAL_W-1:0] entry,
	output logic [blist_pkg::CNT_W-1:0]        removed_count,
	output logic [blist_pkg::CNT_W-1:0]        length
);
	import blist_pkg::*;

	localparam int CW   = $clog2(SIZE + 1);
	localparam int AW   = (SIZE > 1) ? $clog2(SIZE) : 1;
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_WR,
		ST_FND_RD,
		ST_FND_CMP,
		ST_REM_RD,
		ST_REM_CMP,
		ST_RD_WAIT,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic [POS_W-1:0]   pos_q;
	logic [VAL_W-1:0]   val_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      i_q;
	logic [CW-1:0]      wr_q;

	logic               res_ok_q;
	logic               res_found_q;
	logic [IDX_W-1:0]   res_index_q;
	logic [VAL_W-1:0]   res_entry_q;
	logic [CNT_W-1:0]   res_removed_q;

	logic               out_valid_q;
	logic               ok_q;
	logic               found_q;
	logic [IDX_W-1:0]   index_q;
	logic [VAL_W-1:0]   entry_q;
	logic [CNT_W-1:0]   removed_q;
	logic [CNT_W-1:0]   length_q;

	logic [VAL_W-1:0]   mem [SIZE];
	logic [VAL_W-1:0]   rdata_q;
	logic [AW-1:0]      raddr;
	logic               we;
	logic [AW-1:0]      waddr;
	logic [VAL_W-1:0]   wdata;

	logic               eq;
	logic [CW-1:0]      i_inc;
	logic [CW-1:0]      i_dec;
	logic               in_acc;
	logic               out_free;

	blist_alu #(
		.CW(CW)
	) u_alu (
		.a      (rdata_q),
		.b      (val_q),
		.idx    (i_q),
		.eq     (eq),
		.idx_inc(i_inc),
		.idx_dec(i_dec)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// memory port control
	always_comb begin
		raddr = AW'(i_q);
		we    = 1'b0;
		waddr = AW'(i_q);
		wdata = rdata_q;
		unique case (state_q)
			ST_IDLE: begin
				raddr = AW'(position);
			end
			ST_INS_RD: begin
				raddr = AW'(i_dec);
				if (!(CMPW'(i_q) > CMPW'(pos_q))) begin
					we    = 1'b1;
					waddr = AW'(pos_q);
					wdata = val_q;
				end
			end
			ST_INS_WR: begin
				we    = 1'b1;
				waddr = AW'(i_q);
				wdata = rdata_q;
			end
			ST_FND_RD: begin
				raddr = AW'(i_dec);
			end
			ST_REM_RD: begin
				raddr = AW'(i_q);
			end
			ST_REM_CMP: begin
				we    = !eq;
				waddr = AW'(wr_q);
				wdata = rdata_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						pos_q         <= position;
						val_q         <= $unsigned(value);
						res_ok_q      <= 1'b1;
						res_found_q   <= 1'b0;
						res_index_q   <= '0;
						res_entry_q   <= '0;
						res_removed_q <= '0;
						i_q           <= cnt_q;
						wr_q          <= '0;
						unique case (kind)
							KIND_CLEAR: begin
								cnt_q   <= '0;
								state_q <= ST_DONE;
							end
							KIND_INSERT: begin
								if (cnt_q == CW'(SIZE) || CMPW'(position) > CMPW'(cnt_q)) begin
									res_ok_q <= 1'b0;
									state_q  <= ST_DONE;
								end else begin
									state_q <= ST_INS_RD;
								end
							end
							KIND_FIND: begin
								state_q <= ST_FND_RD;
							end
							KIND_REMOVE: begin
								i_q     <= '0;
								state_q <= ST_REM_RD;
							end
							KIND_READ: begin
								if (CMPW'(position) >= CMPW'(cnt_q)) begin
									res_ok_q <= 1'b0;
									state_q  <= ST_DONE;
								end else begin
									state_q <= ST_RD_WAIT;
								end
							end
							default: begin
								res_ok_q <= 1'b0;
								state_q  <= ST_DONE;
							end
						endcase
					end
				end
				ST_INS_RD: begin
					if (CMPW'(i_q) > CMPW'(pos_q)) begin
						state_q <= ST_INS_WR;
					end else begin
						cnt_q   <= cnt_q + CW'(1);
						state_q <= ST_DONE;
					end
				end
				ST_INS_WR: begin
					i_q     <= i_dec;
					state_q <= ST_INS_RD;
				end
				ST_FND_RD: begin
					if (i_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_FND_CMP;
					end
				end
				ST_FND_CMP: begin
					if (eq) begin
						res_found_q <= 1'b1;
						res_index_q <= IDX_W'(i_dec);
						state_q     <= ST_DONE;
					end else begin
						i_q     <= i_dec;
						state_q <= ST_FND_RD;
					end
				end
				ST_REM_RD: begin
					if (i_q == cnt_q) begin
						res_removed_q <= CNT_W'(cnt_q - wr_q);
						cnt_q         <= wr_q;
						state_q       <= ST_DONE;
					end else begin
						state_q <= ST_REM_CMP;
					end
				end
				ST_REM_CMP: begin
					if (!eq) begin
						wr_q <= wr_q + CW'(1);
					end
					i_q     <= i_inc;
					state_q <= ST_REM_RD;
				end
				ST_RD_WAIT: begin
					res_entry_q <= rdata_q;
					state_q     <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						ok_q      <= res_ok_q;
						found_q   <= res_found_q;
						index_q   <= res_index_q;
						entry_q   <= res_entry_q;
						removed_q <= res_removed_q;
						length_q  <= CNT_W'(cnt_q);
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign ok            = ok_q;
	assign found         = found_q;
	assign index         = index_q;
	assign entry         = $signed(entry_q);
	assign removed_count = removed_q;
	assign length        = length_q;

endmodule
